>>> src/msfp_pkg.sv
// Shared types and constants for the MSF timecode parser.
// Used by msfp_parse and msf_timecode_parser_top; no dependencies.
package msfp_pkg;

    // Default digit limit per field.
    localparam int MSFP_MAX_DIGITS = 2;

    // Widest field value the selection path carries.
    localparam int FIELD_W = 7;
    localparam int TOTAL_W = 19;
    localparam int CH_W    = 8;

    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;

    localparam logic [FIELD_W-1:0] SEC_MAX   = 7'd59;
    localparam logic [FIELD_W-1:0] FRAME_MAX = 7'd74;

    localparam logic [12:0] FRAMES_PER_MIN = 13'd4500;
    localparam logic [6:0]  FRAMES_PER_SEC = 7'd75;

    // Minutes, seconds and frames as selected from the captured fields.
    typedef struct packed {
        logic [FIELD_W-1:0] minutes;
        logic [FIELD_W-1:0] seconds;
        logic [FIELD_W-1:0] frames;
    } t_msf;

endpackage

>>> src/msfp_parse.sv
// Character-level parse state for the MSF timecode parser.
// Depends on msfp_pkg for character codes and the t_msf type.
module msfp_parse #(
    parameter int MAX_DIGITS = msfp_pkg::MSFP_MAX_DIGITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic [msfp_pkg::CH_W-1:0] i_ch,
    output msfp_pkg::t_msf            o_msf
);

    localparam int FW  = (MAX_DIGITS == 1) ? 4 : 7;
    localparam int CW  = $clog2(MAX_DIGITS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_DIGITS);

    localparam logic [1:0] PH_SKIP  = 2'd0;
    localparam logic [1:0] PH_FIELD = 2'd1;
    localparam logic [1:0] PH_DONE  = 2'd2;

    localparam logic [1:0] SLOT_LAST = 2'd2;

    logic [1:0]    r_phase, n_phase;
    logic [1:0]    r_slot, n_slot;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [1:0]    r_captured, n_captured;
    logic [FW-1:0] r_val [3];
    logic [FW-1:0] n_val [3];

    logic          is_space, is_digit, is_colon;
    logic [3:0]    digit;
    logic [FW-1:0] cur_val, acc_val;

    assign is_space = (i_ch == msfp_pkg::CH_SPACE) ||
                      (i_ch >= msfp_pkg::CH_TAB && i_ch <= msfp_pkg::CH_CR);
    assign is_digit = (i_ch >= msfp_pkg::CH_ZERO) && (i_ch <= msfp_pkg::CH_NINE);
    assign is_colon = (i_ch == msfp_pkg::CH_COLON);
    assign digit    = 4'(i_ch - msfp_pkg::CH_ZERO);

    always_comb begin
        case (r_slot)
            2'd0:    cur_val = r_val[0];
            2'd1:    cur_val = r_val[1];
            default: cur_val = r_val[2];
        endcase
    end

    // Times ten as two shifts and an add, kept to the field width.
    assign acc_val = FW'((cur_val << 3) + (cur_val << 1) + FW'(digit));

    always_comb begin
        n_phase    = r_phase;
        n_slot     = r_slot;
        n_cnt      = r_cnt;
        n_captured = r_captured;
        n_val      = r_val;
        if (i_ch == msfp_pkg::CH_NUL) begin
            n_phase    = PH_SKIP;
            n_slot     = '0;
            n_cnt      = '0;
            n_captured = '0;
            n_val[0]   = '0;
            n_val[1]   = '0;
            n_val[2]   = '0;
        end else if ((r_phase == PH_FIELD) || (r_phase == PH_SKIP && !is_space)) begin
            n_phase = PH_FIELD;
            if (is_digit && r_cnt < CNT_MAX) begin
                n_val[r_slot] = acc_val;
                n_cnt         = r_cnt + 1'b1;
                n_captured    = r_slot + 2'd1;
            end else if (is_colon && r_cnt != '0 && r_slot != SLOT_LAST) begin
                n_slot = r_slot + 2'd1;
                n_cnt  = '0;
            end else begin
                n_phase = PH_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SKIP;
            r_slot     <= '0;
            r_cnt      <= '0;
            r_captured <= '0;
            r_val[0]   <= '0;
            r_val[1]   <= '0;
            r_val[2]   <= '0;
        end else if (i_en) begin
            r_phase    <= n_phase;
            r_slot     <= n_slot;
            r_cnt      <= n_cnt;
            r_captured <= n_captured;
            r_val      <= n_val;
        end
    end

    // The last captured field is always frames; earlier ones shift up.
    always_comb begin
        o_msf = '0;
        case (r_captured)
            2'd1: begin
                o_msf.frames = msfp_pkg::FIELD_W'(r_val[0]);
            end
            2'd2: begin
                o_msf.seconds = msfp_pkg::FIELD_W'(r_val[0]);
                o_msf.frames  = msfp_pkg::FIELD_W'(r_val[1]);
            end
            2'd3: begin
                o_msf.minutes = msfp_pkg::FIELD_W'(r_val[0]);
                o_msf.seconds = msfp_pkg::FIELD_W'(r_val[1]);
                o_msf.frames  = msfp_pkg::FIELD_W'(r_val[2]);
            end
            default: o_msf = '0;
        endcase
    end

endmodule

>>> src/msf_timecode_parser_top.sv
// A zero byte is held in the input register, then its result beat in the output register.
// Throughput: one character beat per cycle; only a zero byte waits, and only
// while an earlier result beat is still held by the output side.
// Reset (i_rst_n low, synchronous) empties both stages and returns the parse
// to skipping leading whitespace with all fields cleared.
// Top level of the MSF timecode parser; depends on msfp_pkg and msfp_parse.
module msf_timecode_parser_top #(
    parameter int MAX_DIGITS = msfp_pkg::MSFP_MAX_DIGITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] ch
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [18:0] total_frames, [23:19] zero
    output logic        o_m_tuser    // [0] range_error
);

    logic                        r_in_vld;
    logic [msfp_pkg::CH_W-1:0]   r_ch;
    logic                        r_out_vld;
    logic [msfp_pkg::TOTAL_W-1:0] r_total, n_total;
    logic                        r_err, n_err;

    logic                        is_nul, out_free, adv;
    msfp_pkg::t_msf              msf;
    logic [msfp_pkg::TOTAL_W-1:0] min_part, sec_part;

    assign is_nul     = (r_ch == msfp_pkg::CH_NUL);
    assign out_free   = !r_out_vld || i_m_tready;
    assign adv        = r_in_vld && (!is_nul || out_free);
    assign o_s_tready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_ch <= i_s_tdata;
        end
    end

    msfp_parse #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_ch    (r_ch),
        .o_msf   (msf)
    );

    // Both products are formed at the full result width.
    assign min_part = msfp_pkg::TOTAL_W'(msf.minutes)
                    * msfp_pkg::TOTAL_W'(msfp_pkg::FRAMES_PER_MIN);
    assign sec_part = msfp_pkg::TOTAL_W'(msf.seconds)
                    * msfp_pkg::TOTAL_W'(msfp_pkg::FRAMES_PER_SEC);
    assign n_err    = (msf.seconds > msfp_pkg::SEC_MAX) || (msf.frames > msfp_pkg::FRAME_MAX);
    assign n_total  = n_err ? '0
                            : msfp_pkg::TOTAL_W'(min_part + sec_part
                                                 + msfp_pkg::TOTAL_W'(msf.frames));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv && is_nul) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && is_nul) begin
            r_total <= n_total;
            r_err   <= n_err;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {5'b0, r_total};
    assign o_m_tuser  = r_err;

    a_err_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata[18:0] == '0)
        else $error("range error beat carries a nonzero frame count");

    a_total_max : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[18:0] <= 19'd449999)
        else $error("frame count beyond largest valid timecode");

    a_nul_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && is_nul |=> o_m_tvalid)
        else $error("zero byte consumed without a result beat");

    a_char_flows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !is_nul |-> o_s_tready)
        else $error("input stalled behind a non-terminating character");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for msf_timecode_parser_top: streams timecode text one
// character per beat and checks every frame-count beat against its own parser model.
// Depends on msfp_pkg and the parser RTL only.
module testbench;

    localparam int MAXD          = msfp_pkg::MSFP_MAX_DIGITS;
    localparam int SECS_PER_MIN  = 60;
    localparam int LATENCY       = 2;
    localparam int ITEMS_TOTAL   = 1850;
    localparam int HOLD_CYCLES   = 400;

    typedef enum logic [1:0] {
        SCAN_LEAD,
        SCAN_FIELDS,
        SCAN_IGNORE
    } t_scan_phase;

    typedef struct packed {
        logic [msfp_pkg::TOTAL_W-1:0] total;
        logic                         err;
    } t_frame_result;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        ch_valid = 1'b0;
    logic [7:0]  ch_data = 8'h00;
    logic        ch_ready;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [23:0] res_data;
    logic        res_user;

    msf_timecode_parser_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (ch_valid),
        .o_s_tready (ch_ready),
        .i_s_tdata  (ch_data),    // [7:0] ch
        .o_m_tvalid (res_valid),
        .i_m_tready (res_ready),
        .o_m_tdata  (res_data),   // [18:0] total_frames, [23:19] zero
        .o_m_tuser  (res_user)    // [0] range_error
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Parser state mirrored from the block.
    t_scan_phase                  scan_phase;
    logic [1:0]                   scan_slot;
    logic [1:0]                   scan_digits;
    logic [1:0]                   scan_fields;
    logic [msfp_pkg::FIELD_W-1:0] scan_val [3];

    t_frame_result expected_frames [$];
    logic [7:0]    txt [$];
    int            mismatches = 0;
    int            sent_count = 0;

    // Traffic shaping knobs.
    int burst_left   = 0;
    int gap_max      = 0;
    int rx_stall_max = 0;
    int hold_req     = 0;
    int hold_left    = 0;
    int rdy_run      = 0;
    int stall_run    = 0;

    function automatic void clear_parse();
        scan_phase  = SCAN_LEAD;
        scan_slot   = '0;
        scan_digits = '0;
        scan_fields = '0;
        for (int i = 0; i < 3; i++) scan_val[i] = '0;
    endfunction

    function automatic void predict_char(input logic [7:0] c);
        logic [msfp_pkg::FIELD_W-1:0] mm;
        logic [msfp_pkg::FIELD_W-1:0] ss;
        logic [msfp_pkg::FIELD_W-1:0] ff;
        int                           t;
        t_frame_result                r;
        bit                           is_space;
        bit                           is_digit;
        is_space = (c == msfp_pkg::CH_SPACE) ||
                   (c >= msfp_pkg::CH_TAB && c <= msfp_pkg::CH_CR);
        is_digit = (c >= msfp_pkg::CH_ZERO) && (c <= msfp_pkg::CH_NINE);
        if (c == msfp_pkg::CH_NUL) begin
            mm = '0;
            ss = '0;
            ff = '0;
            case (scan_fields)
                2'd1: ff = scan_val[0];
                2'd2: begin
                    ss = scan_val[0];
                    ff = scan_val[1];
                end
                2'd3: begin
                    mm = scan_val[0];
                    ss = scan_val[1];
                    ff = scan_val[2];
                end
                default: ;
            endcase
            r.err = (ss > msfp_pkg::SEC_MAX) || (ff > msfp_pkg::FRAME_MAX);
            t = (int'(mm) * SECS_PER_MIN + int'(ss)) * int'(msfp_pkg::FRAMES_PER_SEC)
                + int'(ff);
            r.total = r.err ? '0 : t[msfp_pkg::TOTAL_W-1:0];
            expected_frames.push_back(r);
            clear_parse();
        end else if (!(scan_phase == SCAN_LEAD && is_space) && scan_phase != SCAN_IGNORE) begin
            scan_phase = SCAN_FIELDS;
            if (scan_digits < MAXD && is_digit) begin
                t = int'(scan_val[scan_slot]) * 10 + int'(c - msfp_pkg::CH_ZERO);
                scan_val[scan_slot] = t[msfp_pkg::FIELD_W-1:0];
                scan_digits = scan_digits + 2'd1;
                scan_fields = scan_slot + 2'd1;
            end else if (c == msfp_pkg::CH_COLON && scan_digits > 0 && scan_slot < 2) begin
                scan_slot   = scan_slot + 2'd1;
                scan_digits = '0;
            end else begin
                scan_phase = SCAN_IGNORE;
            end
        end
    endfunction

    // Starts and ends at a falling edge; keeps tvalid high between back-to-back beats.
    task automatic send_char(input logic [7:0] c);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (gap_max > 0) begin
                gap = $urandom_range(1, gap_max);
                ch_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        ch_valid <= 1'b1;
        ch_data  <= c;
        @(posedge clk);
        while (!ch_ready) @(posedge clk);
        predict_char(c);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic send_text();
        foreach (txt[i]) send_char(txt[i]);
    endtask

    task automatic load_text(input string s);
        txt.delete();
        for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
        txt.push_back(msfp_pkg::CH_NUL);
    endtask

    task automatic wait_results_drained();
        ch_valid <= 1'b0;
        @(negedge clk);
        while (expected_frames.size() != 0) @(negedge clk);
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    function automatic logic [7:0] rand_space();
        int k;
        k = $urandom_range(0, 5);
        return (k == 5) ? msfp_pkg::CH_SPACE : msfp_pkg::CH_TAB + 8'(k);
    endfunction

    function automatic logic [7:0] rand_digit();
        return msfp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // Any non-zero byte, leaning toward the characters the parser cares about.
    function automatic logic [7:0] rand_junk();
        case ($urandom_range(0, 4))
            0: return rand_digit();
            1: return msfp_pkg::CH_COLON;
            2: return rand_space();
            3: return 8'($urandom_range(128, 255));
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // Builds a timecode into txt. A broken one may have empty, overlong or extra fields.
    task automatic build_timecode(input bit broken);
        int nfields;
        int nd;
        int lim;
        int v;
        txt.delete();
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) txt.push_back(rand_space());
        end
        nfields = broken ? $urandom_range(1, 4) : $urandom_range(1, 3);
        for (int f = 0; f < nfields; f++) begin
            if (f > 0) txt.push_back(msfp_pkg::CH_COLON);
            nd  = broken ? $urandom_range(0, 3) : $urandom_range(1, 2);
            lim = (f == nfields - 1) ? 74 : (f == nfields - 2) ? 59 : 99;
            v   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 99) : $urandom_range(0, lim);
            if (nd >= 2) txt.push_back(msfp_pkg::CH_ZERO + 8'(v / 10));
            if (nd >= 1) txt.push_back(msfp_pkg::CH_ZERO + 8'(v % 10));
            if (nd == 3) txt.push_back(rand_digit());
        end
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) txt.push_back(rand_junk());
        end
        txt.push_back(msfp_pkg::CH_NUL);
    endtask

    task automatic build_noise();
        txt.delete();
        repeat ($urandom_range(0, 8)) txt.push_back(rand_junk());
        txt.push_back(msfp_pkg::CH_NUL);
    endtask

    // Receiver: alternating ready and stall runs, plus an occasional long hold-off.
    always @(negedge clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_ready <= 1'b0;
        end else if (rdy_run > 0) begin
            rdy_run--;
            res_ready <= 1'b1;
        end else if (stall_run > 0) begin
            stall_run--;
            res_ready <= 1'b0;
        end else begin
            rdy_run   = $urandom_range(0, 11);
            stall_run = (rx_stall_max > 0) ? $urandom_range(0, rx_stall_max) : 0;
            res_ready <= 1'b1;
        end
    end

    t_frame_result chk_want;

    always @(posedge clk) begin
        if (rst_n && res_valid && res_ready) begin
            if (expected_frames.size() == 0) begin
                $error("result beat with no expectation: total_frames %0d, range_error %0d",
                       res_data[msfp_pkg::TOTAL_W-1:0], res_user);
                mismatches++;
            end else begin
                chk_want = expected_frames.pop_front();
                if (res_data[msfp_pkg::TOTAL_W-1:0] !== chk_want.total) begin
                    $error("total_frames: expected %0d, got %0d",
                           chk_want.total, res_data[msfp_pkg::TOTAL_W-1:0]);
                    mismatches++;
                end
                if (res_user !== chk_want.err) begin
                    $error("range_error: expected %0d, got %0d", chk_want.err, res_user);
                    mismatches++;
                end
                if (res_data[23:msfp_pkg::TOTAL_W] !== '0) begin
                    $error("tdata padding: expected 0, got %0h",
                           res_data[23:msfp_pkg::TOTAL_W]);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_directed();
        gap_max      = 3;
        rx_stall_max = 4;
        // Empty text: no digits at all.
        load_text("");
        send_text();
        // Leading whitespace and the largest valid timecode.
        load_text("99:59:74");
        txt.push_front(msfp_pkg::CH_TAB);
        txt.push_front(msfp_pkg::CH_CR);
        send_text();
        // Seconds and frames both out of range.
        load_text("60:75");
        send_text();
        // Overlong field stops the parse; the later colon and high byte are ignored.
        load_text("123:");
        txt.insert(txt.size() - 1, 8'hFF);
        send_text();
        // Colon before any digit.
        load_text(":5");
        send_text();
    endtask

    task automatic test_full_rate();
        wait_results_drained();
        gap_max      = 0;
        rx_stall_max = 0;
        repeat (40) begin
            build_timecode($urandom_range(0, 3) == 0);
            send_text();
        end
    endtask

    task automatic test_backpressure();
        wait_results_drained();
        gap_max      = 0;
        rx_stall_max = 0;
        @(posedge clk);
        hold_req = HOLD_CYCLES;
        @(negedge clk);
        repeat (24) begin
            build_timecode(1'b0);
            send_text();
        end
        wait_results_drained();
    endtask

    task automatic test_random_text();
        int n;
        int k;
        n = 0;
        while (sent_count < ITEMS_TOTAL) begin
            if (n % 30 == 0) begin
                case ($urandom_range(0, 2))
                    0: gap_max = 0;
                    1: gap_max = 3;
                    default: gap_max = 10;
                endcase
                case ($urandom_range(0, 2))
                    0: rx_stall_max = 0;
                    1: rx_stall_max = 4;
                    default: rx_stall_max = 16;
                endcase
            end
            k = $urandom_range(0, 19);
            if (k < 14) build_timecode(1'b0);
            else if (k < 17) build_timecode(1'b1);
            else build_noise();
            send_text();
            n++;
        end
    endtask

    initial begin
        clear_parse();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_full_rate();
        test_backpressure();
        test_random_text();
        wait_results_drained();
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
